// ----- design/numeric_string_classifier_core_defines.svh -----
// ---------------------------------------------------------------------------
// Numeric string classifier assertion macros
// Concurrent assertion forms for the classifier scanner RTL.
// ---------------------------------------------------------------------------
`ifndef NUMERIC_STRING_CLASSIFIER_CORE_DEFINES_SVH
`define NUMERIC_STRING_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("numeric string classifier: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("numeric string classifier: next-cycle check failed");

`endif

// ----- design/nsc_pkg.sv -----
// ---------------------------------------------------------------------------
// Numeric string classifier package
// Item and result types, scanner states and character codes.
// ---------------------------------------------------------------------------
package nsc_pkg;

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_SIGN   = 3'd1,
    ST_INT    = 3'd2,
    ST_FRAC   = 3'd3,
    ST_EXP    = 3'd4,
    ST_ESIGN  = 3'd5,
    ST_EDIG   = 3'd6,
    ST_REJECT = 3'd7
  } scan_state_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
    logic       empty_string;
  } item_t;

  typedef struct packed {
    logic is_integer;
    logic is_real;
    logic is_numeric;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_beat_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } result_beat_t;

endpackage

// ----- design/nsc_if.sv -----
// ---------------------------------------------------------------------------
// Numeric string classifier channel interfaces
// Valid/ready channels for input bytes and classification results.
// ---------------------------------------------------------------------------
interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;
  logic       empty_string;

  modport source (output valid, output char_byte, output last_byte,
                  output empty_string, input ready);
  modport sink (input valid, input char_byte, input last_byte,
                input empty_string, output ready);
endinterface

interface nsc_out_if;
  logic valid;
  logic ready;
  logic is_integer;
  logic is_real;
  logic is_numeric;

  modport source (output valid, output is_integer, output is_real,
                  output is_numeric, input ready);
  modport sink (input valid, input is_integer, input is_real,
                input is_numeric, output ready);
endinterface

// ----- design/numeric_string_classifier_core.sv -----
// ---------------------------------------------------------------------------
// Numeric string classifier core
// Classifies byte strings as integer, real or numeric literals.
// ---------------------------------------------------------------------------
// Bytes of a string arrive one per transfer on in_ch, the final byte marked
// by last_byte. A transfer with empty_string set stands for a whole empty
// string and abandons any partly scanned string. One result per finished
// string leaves on out_ch; bytes that do not end a string give no result.
// A byte is registered on the transfer edge and scanned in the next cycle.
// The result of a string is formed by the scanner from the input register
// and shown on out_ch once it is captured in the output register.
// Throughput is one byte per cycle unless a result stalls at the output; the
// three-bit recognizer state is updated per byte. A result waiting on out_ch
// does not block input: bytes that do not end a string keep flowing through.
// The scanner stalls only when it must deliver a result while the output
// register is full and out_ch is not ready; the input register then holds
// that byte and in_ch stalls. A stalled result holds its value until the
// transfer. Synchronous reset clears both valid flags and returns the
// recognizer to the start of a string.
// ---------------------------------------------------------------------------
module numeric_string_classifier_core import nsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  nsc_in_if.sink        in_ch,
  nsc_out_if.source     out_ch
);

  item_t        in_item;
  item_beat_t   stage;
  logic         advance;
  logic         res_room;
  result_beat_t res_beat;
  result_t      out_res;

  assign in_item.char_byte    = in_ch.char_byte;
  assign in_item.last_byte    = in_ch.last_byte;
  assign in_item.empty_string = in_ch.empty_string;

  nsc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .advance  (advance),
    .stage    (stage)
  );

  nsc_scanner u_scanner (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .res_room (res_room),
    .advance  (advance),
    .res_out  (res_beat)
  );

  nsc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_in    (res_beat),
    .res_room  (res_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.is_integer = out_res.is_integer;
  assign out_ch.is_real    = out_res.is_real;
  assign out_ch.is_numeric = out_res.is_numeric;

endmodule

// ----- design/nsc_in_reg.sv -----
// ---------------------------------------------------------------------------
// Numeric string classifier input register
// Captures one input item per transfer and holds it until the scanner uses it.
// ---------------------------------------------------------------------------
module nsc_in_reg import nsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  input  logic       advance,
  output item_beat_t stage
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ----- design/nsc_scanner.sv -----
// ---------------------------------------------------------------------------
// Numeric string classifier scanner
// Recognizer state register, byte transition logic and string classification.
// ---------------------------------------------------------------------------
`include "numeric_string_classifier_core_defines.svh"

module nsc_scanner import nsc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  item_beat_t   stage,
  input  logic         res_room,
  output logic         advance,
  output result_beat_t res_out
);

  scan_state_t state_r;
  scan_state_t state_nxt;
  scan_state_t step_state;
  logic        is_dig;
  logic        is_sgn;
  logic        is_exp;
  logic        emit;
  logic [7:0]  c;

  assign c      = stage.item.char_byte;
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_sgn = (c == CH_PLUS) || (c == CH_MINUS);
  assign is_exp = (c == CH_LOW_E) || (c == CH_UP_E);

  always_comb begin
    step_state = ST_REJECT;
    unique case (state_r)
      ST_START: begin
        if (is_sgn) begin
          step_state = ST_SIGN;
        end else if (is_dig) begin
          step_state = ST_INT;
        end
      end
      ST_SIGN: begin
        if (is_dig) begin
          step_state = ST_INT;
        end
      end
      ST_INT: begin
        if (is_dig) begin
          step_state = ST_INT;
        end else if (c == CH_DOT) begin
          step_state = ST_FRAC;
        end else if (is_exp) begin
          step_state = ST_EXP;
        end
      end
      ST_FRAC: begin
        if (is_dig) begin
          step_state = ST_FRAC;
        end else if (is_exp) begin
          step_state = ST_EXP;
        end
      end
      ST_EXP: begin
        if (is_sgn) begin
          step_state = ST_ESIGN;
        end else if (is_dig) begin
          step_state = ST_EDIG;
        end
      end
      ST_ESIGN: begin
        if (is_dig) begin
          step_state = ST_EDIG;
        end
      end
      ST_EDIG: begin
        if (is_dig) begin
          step_state = ST_EDIG;
        end
      end
      ST_REJECT: begin
        step_state = ST_REJECT;
      end
      default: begin
        step_state = ST_REJECT;
      end
    endcase
  end

  assign emit    = stage.item.empty_string || stage.item.last_byte;
  assign advance = stage.valid && (!emit || res_room);

  always_comb begin
    if (!advance) begin
      state_nxt = state_r;
    end else if (emit) begin
      state_nxt = ST_START;
    end else begin
      state_nxt = step_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    res_out.valid = advance && emit;
    if (stage.item.empty_string) begin
      res_out.res = '0;
    end else begin
      res_out.res.is_integer = (step_state == ST_INT);
      res_out.res.is_real    = (step_state == ST_INT) || (step_state == ST_FRAC) ||
                               (step_state == ST_EDIG);
      res_out.res.is_numeric = res_out.res.is_integer || res_out.res.is_real;
    end
  end

  `NSC_ASSERT_NEXT(a_start_after_string, clk, rst_n, res_out.valid, state_r == ST_START)
  `NSC_ASSERT_NEXT(a_state_holds_on_stall, clk, rst_n, !advance, $stable(state_r))
  `NSC_ASSERT_NOW(a_empty_rejected, clk, rst_n, advance && stage.item.empty_string, res_out.valid && !res_out.res.is_numeric)
  `NSC_ASSERT_NOW(a_integer_is_real, clk, rst_n, res_out.valid && res_out.res.is_integer, res_out.res.is_real && res_out.res.is_numeric)

endmodule

// ----- design/nsc_out_reg.sv -----
// ---------------------------------------------------------------------------
// Numeric string classifier output register
// Holds one classification result until the receiver takes it.
// ---------------------------------------------------------------------------
module nsc_out_reg import nsc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  result_beat_t res_in,
  output logic         res_room,
  output logic         out_valid,
  input  logic         out_ready,
  output result_t      out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign res_room = !valid_r || out_ready;

  always_comb begin
    if (res_in.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_in.valid) begin
      res_r <= res_in.res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// Numeric string classifier testbench
// Sends byte strings through the input channel and checks each integer,
// real and numeric flag against a scoreboard that runs its own recognizer.
// ---------------------------------------------------------------------------
module testbench;
  import nsc_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  class literal_scoreboard;
    scan_state_t scan = ST_START;
    result_t     expected_classes[$];
    int          errors = 0;

    function scan_state_t advance(scan_state_t s, logic [7:0] c);
      logic digit, sign, expo;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      sign  = (c == CH_PLUS) || (c == CH_MINUS);
      expo  = (c == CH_LOW_E) || (c == CH_UP_E);
      case (s)
        ST_START: begin
          if (sign) return ST_SIGN;
          if (digit) return ST_INT;
          return ST_REJECT;
        end
        ST_SIGN: return digit ? ST_INT : ST_REJECT;
        ST_INT: begin
          if (digit) return ST_INT;
          if (c == CH_DOT) return ST_FRAC;
          if (expo) return ST_EXP;
          return ST_REJECT;
        end
        ST_FRAC: begin
          if (digit) return ST_FRAC;
          if (expo) return ST_EXP;
          return ST_REJECT;
        end
        ST_EXP: begin
          if (sign) return ST_ESIGN;
          if (digit) return ST_EDIG;
          return ST_REJECT;
        end
        ST_ESIGN: return digit ? ST_EDIG : ST_REJECT;
        ST_EDIG: return digit ? ST_EDIG : ST_REJECT;
        default: return ST_REJECT;
      endcase
    endfunction

    function void note_byte(item_t it);
      scan_state_t nxt;
      result_t     cls;
      cls = '0;
      nxt = advance(scan, it.char_byte);
      if (it.empty_string) begin
        scan = ST_START;
        expected_classes.push_back(cls);
      end else if (it.last_byte) begin
        cls.is_integer = (nxt == ST_INT);
        cls.is_real    = (nxt == ST_INT) || (nxt == ST_FRAC) || (nxt == ST_EDIG);
        cls.is_numeric = cls.is_integer | cls.is_real;
        scan = ST_START;
        expected_classes.push_back(cls);
      end else begin
        scan = nxt;
      end
    endfunction

    function void compare_field(string name, logic want, logic seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s expected %b actual %b", $time, name, want, seen);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_classes.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %b", $time, got);
      end else begin
        want = expected_classes.pop_front();
        compare_field("is_integer", want.is_integer, got.is_integer);
        compare_field("is_real", want.is_real, got.is_real);
        compare_field("is_numeric", want.is_numeric, got.is_numeric);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   item_count = 0;
  int   hold_left = 0;
  bit   quiet = 1'b0;
  bit   press_go = 1'b0;
  bit   press_done = 1'b0;
  literal_scoreboard sb;

  nsc_in_if  in_ch();
  nsc_out_if out_ch();

  numeric_string_classifier_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 100000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (press_go && !press_done) begin
      hold_left  = 150;
      press_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = quiet || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{is_integer: out_ch.is_integer, is_real: out_ch.is_real,
                        is_numeric: out_ch.is_numeric});
  end

  task automatic send_item(item_t it);
    while (!quiet && $urandom_range(99) < 13) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.char_byte    = it.char_byte;
    in_ch.last_byte    = it.last_byte;
    in_ch.empty_string = it.empty_string;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(it);
    item_count++;
    @(negedge clk);
  endtask

  task automatic send_empty(logic [7:0] c, logic last);
    item_t it;
    it.char_byte    = c;
    it.last_byte    = last;
    it.empty_string = 1'b1;
    send_item(it);
  endtask

  // A string may be cut short by an empty-string marker when abandoning is allowed.
  task automatic send_text(byte_q_t txt, bit may_abandon);
    item_t it;
    for (int i = 0; i < txt.size(); i++) begin
      if (may_abandon && i < txt.size() - 1 && $urandom_range(99) < 3) begin
        send_empty(8'($urandom_range(255)), 1'($urandom_range(1)));
        break;
      end
      it.char_byte    = txt[i];
      it.last_byte    = (i == txt.size() - 1);
      it.empty_string = 1'b0;
      send_item(it);
    end
  endtask

  function automatic logic [7:0] any_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] any_sign();
    return $urandom_range(1) ? CH_MINUS : CH_PLUS;
  endfunction

  function automatic int digit_run(int most);
    return ($urandom_range(9) == 0) ? 0 : $urandom_range(1, most);
  endfunction

  task automatic send_random_string();
    byte_q_t txt;
    int      kind, n;
    kind = $urandom_range(99);
    if (kind < 7) begin
      send_empty(8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      if (kind < 17) begin
        n = $urandom_range(1, 6);
        repeat (n) txt.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(1)) txt.push_back(any_sign());
        n = digit_run(4);
        repeat (n) txt.push_back(any_digit());
        if ($urandom_range(99) < 40) begin
          txt.push_back(CH_DOT);
          n = $urandom_range(3);
          repeat (n) txt.push_back(any_digit());
        end
        if ($urandom_range(99) < 35) begin
          txt.push_back($urandom_range(1) ? CH_LOW_E : CH_UP_E);
          if ($urandom_range(1)) txt.push_back(any_sign());
          n = digit_run(3);
          repeat (n) txt.push_back(any_digit());
        end
        if (txt.size() == 0) txt.push_back(8'($urandom_range(255)));
        if (kind < 27) txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
      end
      send_text(txt, 1'b1);
    end
  endtask

  initial begin
    sb                 = new;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.char_byte    = '0;
    in_ch.last_byte    = 1'b0;
    in_ch.empty_string = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    send_empty(8'h00, 1'b0);
    send_text({CH_NINE}, 1'b0);
    send_text({CH_PLUS, CH_ZERO, CH_NINE}, 1'b0);
    send_text({any_digit(), CH_DOT}, 1'b0);
    send_text({CH_MINUS, CH_UP_E, CH_MINUS, CH_ZERO}, 1'b0);
    send_text({any_digit(), CH_UP_E, CH_MINUS, any_digit()}, 1'b0);
    send_text({any_digit(), CH_DOT, any_digit(), CH_LOW_E}, 1'b0);
    send_text({8'h00}, 1'b0);
    send_text({8'hFF}, 1'b0);
    send_text({CH_MINUS}, 1'b0);
    send_empty(8'h00, 1'b0);
    send_empty(CH_ZERO + 8'd5, 1'b1);
    send_text({CH_DOT}, 1'b0);
    send_text({8'h3A, any_digit()}, 1'b0);
    send_text({8'h2F}, 1'b0);

    while (item_count < 925) begin
      quiet = (item_count >= 300) && (item_count < 450);
      if (item_count >= 600) press_go = 1'b1;
      send_random_string();
    end
    quiet       = 1'b0;
    in_ch.valid = 1'b0;

    while (sb.expected_classes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- numeric_string_classifier_core.f -----
+incdir+design
design/nsc_pkg.sv
design/nsc_if.sv
design/nsc_in_reg.sv
design/nsc_scanner.sv
design/nsc_out_reg.sv
design/numeric_string_classifier_core.sv
verif/testbench.sv
